>>> rtl/hatd_pkg.sv
// ----------------------------------------------------------------------------
// hatd_pkg
// Shared constants, codes and controller/datapath struct types for the
// heap-array Huffman tree decoder.
// ----------------------------------------------------------------------------
package hatd_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = 10;
    localparam int SIZE_W      = 11;
    localparam int SYM_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int PAD_W       = 3;
    localparam int POS_W       = 4;
    localparam int CHILD_W     = IDX_W + 2;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    // first data bit of a message's header byte
    localparam logic [POS_W-1:0] HDR_START = POS_W'(3);
    localparam logic [POS_W-1:0] BYTE_BITS = POS_W'(8);

    // input command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_ZERO_SYM   = 1'b0;
    localparam logic REG_TABLE_SIZE = 1'b1;

    localparam logic [IDX_W-1:0]  ZERO_SYM_RST   = '0;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(3);

    typedef struct packed {
        logic load;      // write one table entry from the input item
        logic start;     // capture a decode item
        logic rd_en;     // compute child and read its table entry
        logic step;      // apply leaf check for the read child
        logic flush;     // end of item: release pending symbol
    } hatd_cmd_t;

    typedef struct packed {
        logic more_bits;
        logic is_leaf;
        logic pend_valid;
        logic out_free;
    } hatd_stat_t;

endpackage

>>> rtl/hatd_if.sv
// ----------------------------------------------------------------------------
// hatd_in_if / hatd_out_if
// Valid/ready channels for decoder input items and decoded symbol items.
// ----------------------------------------------------------------------------
interface hatd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [hatd_pkg::IDX_W-1:0]    entry_index;
    logic [hatd_pkg::SYM_W-1:0]    entry_symbol;
    logic [hatd_pkg::BYTE_W-1:0]   data_byte;
    logic                          final_byte;

    modport source (output valid, cmd, entry_index, entry_symbol, data_byte, final_byte,
                    input ready);
    modport sink   (input valid, cmd, entry_index, entry_symbol, data_byte, final_byte,
                    output ready);
endinterface

interface hatd_out_if;
    logic                          valid;
    logic                          ready;
    logic [hatd_pkg::SYM_W-1:0]    symbol;
    logic                          last_of_item;

    modport source (output valid, symbol, last_of_item, input ready);
    modport sink   (input valid, symbol, last_of_item, output ready);
endinterface

>>> rtl/hatd_ctrl.sv
// ----------------------------------------------------------------------------
// hatd_ctrl
// Controller state machine: sequences table loads and the per-bit walk.
// ----------------------------------------------------------------------------
module hatd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_cmd,
    output logic                  in_ready,
    input  hatd_pkg::hatd_stat_t  status,
    output hatd_pkg::hatd_cmd_t   ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall;

    // a leaf found while a symbol is pending needs a free output register
    assign stall = status.is_leaf && status.pend_valid && !status.out_free;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (in_cmd == hatd_pkg::CMD_LOAD))
                begin
                    ctrl.load = 1'b1;
                end
                else if (in_valid)
                begin
                    ctrl.start = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (status.more_bits)
                begin
                    ctrl.rd_en = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_CHECK:
            begin
                if (!stall)
                begin
                    ctrl.step  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_FLUSH:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    ctrl.flush = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/hatd_datapath.sv
// ----------------------------------------------------------------------------
// hatd_datapath
// Tree table memory, walk state, bit position and the symbol output stages.
// ----------------------------------------------------------------------------
module hatd_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  hatd_pkg::hatd_cmd_t               ctrl,
    output hatd_pkg::hatd_stat_t              status,
    input  logic [hatd_pkg::IDX_W-1:0]        zero_sym,
    input  logic [hatd_pkg::SIZE_W-1:0]       table_size,
    input  logic [hatd_pkg::IDX_W-1:0]        entry_index,
    input  logic [hatd_pkg::SYM_W-1:0]        entry_symbol,
    input  logic [hatd_pkg::BYTE_W-1:0]       data_byte,
    input  logic                              final_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hatd_pkg::SYM_W-1:0]        out_symbol,
    output logic                              out_last
);

    logic [hatd_pkg::SYM_W-1:0]   tree_mem [hatd_pkg::TABLE_DEPTH];
    logic [hatd_pkg::SYM_W-1:0]   rd_data_reg;

    logic [hatd_pkg::IDX_W-1:0]   node_reg;
    logic                         header_reg;
    logic [hatd_pkg::PAD_W-1:0]   pad_reg;
    logic [hatd_pkg::POS_W-1:0]   pos_reg;
    logic [hatd_pkg::POS_W-1:0]   stop_reg;
    logic [hatd_pkg::BYTE_W-1:0]  byte_reg;
    logic                         fin_reg;
    logic [hatd_pkg::CHILD_W-1:0] child_reg;
    logic                         oob_reg;

    logic                         pend_valid_reg;
    logic [hatd_pkg::SYM_W-1:0]   pend_sym_reg;
    logic                         out_valid_reg;
    logic [hatd_pkg::SYM_W-1:0]   out_sym_reg;
    logic                         out_last_reg;

    logic [hatd_pkg::PAD_W-1:0]   pad_next;
    logic [hatd_pkg::POS_W-1:0]   stop_next;
    logic                         cur_bit;
    logic [hatd_pkg::CHILD_W-1:0] child_next;
    logic [hatd_pkg::SIZE_W-1:0]  lim;
    logic [hatd_pkg::CHILD_W:0]   grand;
    logic                         is_leaf;
    logic [hatd_pkg::SYM_W-1:0]   leaf_sym;
    logic                         out_free;
    logic                         push_mid;
    logic                         push_last;

    // header byte carries the pad count in its top bits
    assign pad_next  = header_reg ? data_byte[hatd_pkg::BYTE_W-1 -: hatd_pkg::PAD_W]
                                  : pad_reg;
    assign stop_next = final_byte ? (hatd_pkg::BYTE_BITS - hatd_pkg::POS_W'(pad_next))
                                  : hatd_pkg::BYTE_BITS;

    // msb first: position p reads bit 7-p
    assign cur_bit    = byte_reg[~pos_reg[hatd_pkg::PAD_W-1:0]];
    assign child_next = {1'b0, node_reg, 1'b0} + hatd_pkg::CHILD_W'(1)
                        + hatd_pkg::CHILD_W'(cur_bit);

    assign lim   = (table_size > hatd_pkg::SIZE_W'(hatd_pkg::TABLE_DEPTH))
                   ? hatd_pkg::SIZE_W'(hatd_pkg::TABLE_DEPTH) : table_size;
    assign grand = {child_reg, 1'b0} + (hatd_pkg::CHILD_W+1)'(2);

    assign is_leaf  = oob_reg || (rd_data_reg != '0)
                      || (child_reg == hatd_pkg::CHILD_W'(zero_sym))
                      || (grand >= (hatd_pkg::CHILD_W+1)'(lim));
    assign leaf_sym = oob_reg ? '0 : rd_data_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign push_mid  = ctrl.step && is_leaf && pend_valid_reg;
    assign push_last = ctrl.flush && pend_valid_reg;

    assign status.more_bits  = (pos_reg < stop_reg);
    assign status.is_leaf    = is_leaf;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_sym_reg;
    assign out_last   = out_last_reg;

    // table memory: one write port for loads, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            tree_mem[entry_index] <= entry_symbol;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= tree_mem[child_next[hatd_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            byte_reg <= data_byte;
            fin_reg  <= final_byte;
            stop_reg <= stop_next;
        end
        if (ctrl.rd_en)
        begin
            child_reg <= child_next;
            oob_reg   <= (child_next >= hatd_pkg::CHILD_W'(hatd_pkg::TABLE_DEPTH));
        end
        if (ctrl.step && is_leaf)
        begin
            pend_sym_reg <= leaf_sym;
        end
        if (push_mid || push_last)
        begin
            out_sym_reg  <= pend_sym_reg;
            out_last_reg <= push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg       <= '0;
            header_reg     <= 1'b1;
            pad_reg        <= '0;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.start)
            begin
                header_reg <= 1'b0;
                pad_reg    <= pad_next;
                pos_reg    <= header_reg ? hatd_pkg::HDR_START : '0;
            end
            if (ctrl.step)
            begin
                pos_reg  <= pos_reg + hatd_pkg::POS_W'(1);
                node_reg <= is_leaf ? '0 : child_reg[hatd_pkg::IDX_W-1:0];
                if (is_leaf)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (ctrl.flush)
            begin
                pend_valid_reg <= 1'b0;
                if (fin_reg)
                begin
                    node_reg   <= '0;
                    header_reg <= 1'b1;
                end
            end
            if (push_mid || push_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/huffman_array_tree_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_array_tree_decoder_unit
// Huffman decoder walking a heap-layout code tree held in on-chip memory.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A load item (cmd 0) writes one entry of
// the 1024-entry tree table in the cycle it is accepted, and the block is
// ready again the next cycle. A decode item (cmd 1) walks its data bits msb
// first: for each bit the read state computes the child index 2i+1+bit and
// reads the table through the single registered read port, and the check
// state then tests whether the child is a leaf. The walk ends when the read
// state finds no bit left, and the flush state releases the pending symbol. A
// full byte walks eight bits, a message's header byte at most five; the output
// side can stall the check and flush states. Each leaf gives one symbol item;
// the newest symbol is held back one leaf so that the last symbol of an input
// item carries last_of_item. The table is not cleared at reset: entries must be
// loaded before they are walked. Registers (apb, 32-bit data): 0x0
// zero_symbol_index, 0x4 table_size; write them only while the block is idle.
// ----------------------------------------------------------------------------
module huffman_array_tree_decoder_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hatd_pkg::ADDR_W-1:0]       paddr,
    input  logic [hatd_pkg::DATA_W-1:0]       pwdata,
    output logic [hatd_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    // item channels
    hatd_in_if.sink                           in_ch,
    hatd_out_if.source                        out_ch
);

    logic [hatd_pkg::IDX_W-1:0]  zero_sym_reg;
    logic [hatd_pkg::SIZE_W-1:0] table_size_reg;
    logic                        cfg_wr;
    logic                        reg_sel;

    hatd_pkg::hatd_cmd_t         ctrl;
    hatd_pkg::hatd_stat_t        status;

    // apb: pready is always high, register chosen by the word address bit
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_sym_reg   <= hatd_pkg::ZERO_SYM_RST;
            table_size_reg <= hatd_pkg::TABLE_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == hatd_pkg::REG_ZERO_SYM)
            begin
                zero_sym_reg <= pwdata[hatd_pkg::IDX_W-1:0];
            end
            else
            begin
                table_size_reg <= pwdata[hatd_pkg::SIZE_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (reg_sel)
            hatd_pkg::REG_ZERO_SYM:   prdata = hatd_pkg::DATA_W'(zero_sym_reg);
            hatd_pkg::REG_TABLE_SIZE: prdata = hatd_pkg::DATA_W'(table_size_reg);
            default:                  prdata = '0;
        endcase
    end

    // sequencing of loads and the bit walk
    hatd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.cmd),
        .in_ready (in_ch.ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    // table memory, walk state and output register
    hatd_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .zero_sym     (zero_sym_reg),
        .table_size   (table_size_reg),
        .entry_index  (in_ch.entry_index),
        .entry_symbol (in_ch.entry_symbol),
        .data_byte    (in_ch.data_byte),
        .final_byte   (in_ch.final_byte),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_symbol   (out_ch.symbol),
        .out_last     (out_ch.last_of_item)
    );

`ifndef SYNTH
    // a symbol is never moved into an occupied output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && status.is_leaf && status.pend_valid) |-> status.out_free)
        else $error("mid-item symbol push into busy output");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.flush && status.pend_valid) |-> status.out_free)
        else $error("last symbol push into busy output");

    // nothing is held back once the block is ready for a new item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !status.pend_valid)
        else $error("pending symbol left behind at item end");

    // a decode item blocks the input until its walk is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.cmd == hatd_pkg::CMD_DECODE))
        |=> !in_ch.ready)
        else $error("input accepted during a walk");
`endif

endmodule

>>> test/huffman_array_tree_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_array_tree_decoder_unit_tb
// Self-checking bench for the heap-array Huffman tree decoder: loads the tree
// table, decodes directed and random messages under several register settings
// and compares every symbol item against a cycle-free model of the walk.
// ----------------------------------------------------------------------------
module huffman_array_tree_decoder_unit_tb;

    // drain, watchdog, random traffic and gap tuning
    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 90;
    localparam int MAX_GAP        = 11;

    // only the top of the tree is loaded; entries past MAX_INNER always hold
    // a symbol, so no walk ever leaves the loaded region
    localparam int FILL_DEPTH     = 15;
    localparam int MAX_INNER      = (FILL_DEPTH - 3) / 2;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [hatd_pkg::ADDR_W-1:0]     paddr;
    logic [hatd_pkg::DATA_W-1:0]     pwdata;
    logic [hatd_pkg::DATA_W-1:0]     prdata;
    logic                            pready;

    hatd_in_if  in_ch ();
    hatd_out_if out_ch ();

    huffman_array_tree_decoder_unit u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // one decoded symbol as the block should deliver it
    typedef struct packed {
        logic [hatd_pkg::SYM_W-1:0] symbol;
        logic                       last_of_item;
    } sym_item_t;

    sym_item_t                    pending_syms [$];

    // shadow of the tree memory, the walk and the registers
    logic [hatd_pkg::SYM_W-1:0]   tree_mem [hatd_pkg::TABLE_DEPTH];
    int                           walk_node;
    bit                           hdr_pending;
    int                           pad_cnt;
    int                           cfg_zero_sym;
    int                           cfg_table_size;

    // run bookkeeping
    bit                 idle_on;
    int                 fail_count;
    int                 n_items;
    int                 n_loads;
    int                 n_decodes;
    int                 n_msgs;
    int                 n_syms;
    int                 n_reg_writes;
    int                 quiet_cycles;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // walk model: applies one accepted item and queues the symbols it yields
    // ------------------------------------------------------------------------
    function automatic void walk_item(input logic cmd_v,
                                      input logic [hatd_pkg::IDX_W-1:0] idx_v,
                                      input logic [hatd_pkg::SYM_W-1:0] sym_v,
                                      input logic [hatd_pkg::BYTE_W-1:0] data_v,
                                      input logic fin_v);
        int                         first_pos;
        int                         stop_pos;
        int                         child;
        int                         limit;
        int                         bit_v;
        logic [hatd_pkg::SYM_W-1:0] leaf_syms [$];
        sym_item_t                  it;

        if (cmd_v == hatd_pkg::CMD_LOAD)
        begin
            tree_mem[idx_v] = sym_v;
            return;
        end

        // the header byte carries the pad count in its top three bits
        first_pos = 0;
        if (hdr_pending)
        begin
            pad_cnt     = data_v[7:5];
            hdr_pending = 1'b0;
            first_pos   = hatd_pkg::HDR_START;
        end
        stop_pos = fin_v ? int'(hatd_pkg::BYTE_BITS) - pad_cnt : int'(hatd_pkg::BYTE_BITS);
        limit    = (cfg_table_size > hatd_pkg::TABLE_DEPTH) ? hatd_pkg::TABLE_DEPTH
                                                             : cfg_table_size;

        for (int pos = first_pos; pos < stop_pos; pos++)
        begin
            bit_v = data_v[7 - pos];
            child = walk_node * 2 + 1 + bit_v;
            if (child >= hatd_pkg::TABLE_DEPTH)
            begin
                // off the end of the memory: leaf with symbol zero
                leaf_syms.insert(leaf_syms.size(), hatd_pkg::SYM_W'(0));
                walk_node = 0;
            end
            else if (tree_mem[child] != '0 || child == cfg_zero_sym ||
                     child * 2 + 2 >= limit)
            begin
                leaf_syms.insert(leaf_syms.size(), tree_mem[child]);
                walk_node = 0;
            end
            else
            begin
                walk_node = child;
            end
        end

        foreach (leaf_syms[k])
        begin
            it.symbol       = leaf_syms[k];
            it.last_of_item = (k == leaf_syms.size() - 1);
            pending_syms.insert(pending_syms.size(), it);
        end

        // end of message: back to the root and expect a new header
        if (fin_v)
        begin
            walk_node   = 0;
            hdr_pending = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // sender: random gap when idle_on is set, then hold the item until the block takes it
    // ------------------------------------------------------------------------
    task automatic send_item(input logic cmd_v, input logic [hatd_pkg::IDX_W-1:0] idx_v,
                             input logic [hatd_pkg::SYM_W-1:0] sym_v,
                             input logic [hatd_pkg::BYTE_W-1:0] data_v, input logic fin_v);
        int gap;

        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= cmd_v;
        in_ch.entry_index  <= idx_v;
        in_ch.entry_symbol <= sym_v;
        in_ch.data_byte    <= data_v;
        in_ch.final_byte   <= fin_v;
        do
            @(posedge clk);
        while (!in_ch.ready);
        walk_item(cmd_v, idx_v, sym_v, data_v, fin_v);
        n_items++;
        if (cmd_v == hatd_pkg::CMD_LOAD)
            n_loads++;
        else
            n_decodes++;
    endtask

    // load item; the decode fields are don't-care and get random values
    task automatic load_entry(input int idx_v, input int sym_v);
        send_item(hatd_pkg::CMD_LOAD, hatd_pkg::IDX_W'(idx_v), hatd_pkg::SYM_W'(sym_v),
                  hatd_pkg::BYTE_W'($urandom), 1'($urandom));
    endtask

    // decode item; the load fields are don't-care and get random values
    task automatic decode_byte(input int data_v, input bit fin_v);
        send_item(hatd_pkg::CMD_DECODE, hatd_pkg::IDX_W'($urandom),
                  hatd_pkg::SYM_W'($urandom), hatd_pkg::BYTE_W'(data_v), fin_v);
        if (fin_v)
            n_msgs++;
    endtask

    // well-formed message: header byte with random pad count, then data
    task automatic send_message(input int n_bytes);
        for (int b = 0; b < n_bytes; b++)
            decode_byte($urandom_range(0, 255), b == n_bytes - 1);
    endtask

    // ------------------------------------------------------------------------
    // drain: stop sending, wait for every symbol, then let the block settle
    // (an item with no symbols may still be walking)
    // ------------------------------------------------------------------------
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_syms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // apb write with setup and access cycle, then read back the register
    // ------------------------------------------------------------------------
    task automatic set_register(input logic reg_idx, input int value);
        logic [hatd_pkg::DATA_W-1:0] wr_val;

        wr_val = hatd_pkg::DATA_W'(value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= wr_val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_idx == hatd_pkg::REG_ZERO_SYM)
            cfg_zero_sym = value;
        else
            cfg_table_size = value;
        n_reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;

        // readback of the same register
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== wr_val)
        begin
            $error("prdata: expected %0h, actual %0h", wr_val, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // receiver: when idle_on is set, random stall before each symbol item
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;

        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready));
        end
    end

    // ------------------------------------------------------------------------
    // symbol checker: each accepted item against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sym_item_t want;

        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_syms++;
            if (pending_syms.size() == 0)
            begin
                $error("unexpected symbol item: symbol %0h, last_of_item %0b",
                       out_ch.symbol, out_ch.last_of_item);
                fail_count++;
            end
            else
            begin
                want = pending_syms.pop_front();
                if (out_ch.symbol !== want.symbol)
                begin
                    $error("symbol: expected %0h, actual %0h", want.symbol, out_ch.symbol);
                    fail_count++;
                end
                if (out_ch.last_of_item !== want.last_of_item)
                begin
                    $error("last_of_item: expected %0b, actual %0b",
                           want.last_of_item, out_ch.last_of_item);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any handshake on any port ends the run
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("huffman_array_tree_decoder_unit_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // load the top of the tree once; low indexes are mostly internal nodes,
    // the rest always hold a symbol so every walk stays in loaded entries
    task automatic test_table_load();
        set_register(hatd_pkg::REG_ZERO_SYM, 0);
        set_register(hatd_pkg::REG_TABLE_SIZE, hatd_pkg::TABLE_DEPTH);
        for (int i = 0; i < FILL_DEPTH; i++)
        begin
            if (i >= 1 && i <= MAX_INNER && $urandom_range(0, 3) != 0)
                load_entry(i, 0);
            else
                load_entry(i, $urandom_range(1, 255));
        end
        wait_idle();
    endtask

    // field extremes, zero-symbol leaf, load in the middle of a message
    task automatic test_directed_basics();
        set_register(hatd_pkg::REG_ZERO_SYM, 3);
        load_entry(hatd_pkg::TABLE_DEPTH - 1, 255);
        load_entry(0, 255);                 // root entry is never used
        load_entry(1, 0);                   // internal node on the left path
        load_entry(3, 0);                   // zero entry at the zero-symbol index
        decode_byte(8'h00, 1'b0);           // header, pad 0, left path to the zero leaf
        decode_byte(8'hFF, 1'b0);
        decode_byte(8'h00, 1'b0);
        decode_byte(8'hA5, 1'b1);           // all eight bits walked
        decode_byte(8'h40, 1'b0);           // header, pad 2
        load_entry(5, 8'h42);               // table change mid-message
        decode_byte(8'hFF, 1'b1);
        decode_byte(8'h7F, 1'b0);           // header, pad 3
        decode_byte(8'h00, 1'b1);
        wait_idle();
    endtask

    // first byte that also ends the message, with and without data bits left
    task automatic test_header_final();
        decode_byte(8'hFF, 1'b1);           // pad 7: nothing to walk
        decode_byte(8'hA0, 1'b1);           // pad 5: nothing to walk
        decode_byte(8'h9F, 1'b1);           // pad 4: one bit
        decode_byte(8'h00, 1'b1);           // pad 0: five bits
        wait_idle();
    endtask

    // smallest table: both root children are leaves, one symbol per walked bit
    task automatic test_small_table();
        set_register(hatd_pkg::REG_TABLE_SIZE, 3);
        set_register(hatd_pkg::REG_ZERO_SYM, 0);
        load_entry(1, 8'h11);
        load_entry(2, 8'hEE);
        decode_byte(8'h00, 1'b0);
        decode_byte(8'hFF, 1'b0);
        decode_byte(8'h55, 1'b1);
        wait_idle();
    endtask

    // register extremes: oversized table size and the top zero-symbol index
    task automatic test_register_extremes();
        set_register(hatd_pkg::REG_TABLE_SIZE, (1 << hatd_pkg::SIZE_W) - 1);
        set_register(hatd_pkg::REG_ZERO_SYM, hatd_pkg::TABLE_DEPTH - 1);
        load_entry(1, 0);
        load_entry(2, 0);
        decode_byte(8'h0C, 1'b0);
        decode_byte(8'h96, 1'b1);
        wait_idle();
    endtask

    // random messages, table updates and noise under changing settings
    task automatic test_random_traffic();
        int  start_items;
        int  next_cfg;
        bit  paused;
        int  pick;
        int  n_upd;

        start_items = n_items;
        next_cfg    = n_items;
        paused      = 1'b0;
        while (n_items - start_items < RANDOM_ITEMS)
        begin
            if (n_items >= next_cfg)
            begin
                wait_idle();
                case ($urandom_range(0, 4))
                    0:       set_register(hatd_pkg::REG_TABLE_SIZE, 3);
                    1:       set_register(hatd_pkg::REG_TABLE_SIZE, hatd_pkg::TABLE_DEPTH);
                    2:       set_register(hatd_pkg::REG_TABLE_SIZE,
                                          $urandom_range(hatd_pkg::TABLE_DEPTH + 1,
                                                         (1 << hatd_pkg::SIZE_W) - 1));
                    3:       set_register(hatd_pkg::REG_TABLE_SIZE, $urandom_range(3, 100));
                    default: set_register(hatd_pkg::REG_TABLE_SIZE,
                                          $urandom_range(3, hatd_pkg::TABLE_DEPTH));
                endcase
                case ($urandom_range(0, 3))
                    0:       set_register(hatd_pkg::REG_ZERO_SYM, 0);
                    1:       set_register(hatd_pkg::REG_ZERO_SYM, hatd_pkg::TABLE_DEPTH - 1);
                    default: set_register(hatd_pkg::REG_ZERO_SYM, $urandom_range(1, 40));
                endcase
                next_cfg = n_items + 30;
            end

            // once, hold off the sender until the block has fully drained
            if (!paused && n_items - start_items >= RANDOM_ITEMS / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end

            idle_on = ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 9);
            if (pick < 7)
            begin
                send_message($urandom_range(1, 5));
            end
            else if (pick < 9)
            begin
                // reshape the upper tree: internal nodes only near the root
                n_upd = $urandom_range(1, 4);
                repeat (n_upd)
                begin
                    if ($urandom_range(0, 1))
                        load_entry($urandom_range(1, MAX_INNER), 0);
                    else
                        load_entry($urandom_range(0, hatd_pkg::TABLE_DEPTH - 1),
                                   $urandom_range(1, 255));
                end
            end
            else
            begin
                // noise: lone byte with a random end flag
                decode_byte($urandom_range(0, 255), 1'($urandom));
            end
        end
        idle_on = 1'b1;
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.cmd          = hatd_pkg::CMD_LOAD;
        in_ch.entry_index  = '0;
        in_ch.entry_symbol = '0;
        in_ch.data_byte    = '0;
        in_ch.final_byte   = 1'b0;
        walk_node          = 0;
        hdr_pending        = 1'b1;
        pad_cnt            = 0;
        cfg_zero_sym       = int'(hatd_pkg::ZERO_SYM_RST);
        cfg_table_size     = int'(hatd_pkg::TABLE_SIZE_RST);
        idle_on            = 1'b1;
        fail_count         = 0;
        n_items            = 0;
        n_loads            = 0;
        n_decodes          = 0;
        n_msgs             = 0;
        n_syms             = 0;
        n_reg_writes       = 0;
        quiet_cycles       = 0;

        // single reset at the start of the run
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_load();
        test_directed_basics();
        test_header_final();
        test_small_table();
        test_register_extremes();
        test_random_traffic();

        if (pending_syms.size() != 0)
        begin
            $error("%0d symbol items never arrived", pending_syms.size());
            fail_count++;
        end

        $display("run covered %0d loads and %0d decode bytes in %0d messages",
                 n_loads, n_decodes, n_msgs);
        $display("checked %0d symbol items across %0d register writes, %0d mismatches",
                 n_syms, n_reg_writes, fail_count);
        if (fail_count == 0)
            $display("huffman_array_tree_decoder_unit_tb: PASS");
        else
            $display("huffman_array_tree_decoder_unit_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/hatd_pkg.sv
rtl/hatd_if.sv
rtl/hatd_ctrl.sv
rtl/hatd_datapath.sv
rtl/huffman_array_tree_decoder_unit.sv
test/huffman_array_tree_decoder_unit_tb.sv
